FILE: design/byte_playfair_cipher_stream_defines.svh
// assertion helpers for the playfair stream block
`ifndef BYTE_PLAYFAIR_CIPHER_STREAM_DEFINES_SVH
`define BYTE_PLAYFAIR_CIPHER_STREAM_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define BPC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define BPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: design/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int SQUARE_SIDE = 16;
	localparam int CELLS       = 256;
	localparam logic [7:0] FILLER = 8'hFF;
	localparam int MAX_RESULTS = 4;

	localparam logic [1:0] CMD_KEY_BYTE = 2'd0;
	localparam logic [1:0] CMD_KEY_DONE = 2'd1;
	localparam logic [1:0] CMD_ENCRYPT  = 2'd2;
	localparam logic [1:0] CMD_DECRYPT  = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] symbol;
		logic       message_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       run_last;
		logic       message_end;
		logic       odd_length_error;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_KEY,
		OP_DONE,
		OP_ENC,
		OP_DEC
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] symbol;
		logic       last;
	} work_t;

	typedef struct packed {
		logic       draining;
		logic [2:0] res_n;
	} bpc_status_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_KEY,
		B_FILL,
		B_ENC0,
		B_PUSH,
		B_POS,
		B_SQ,
		B_MAP,
		B_AFTER,
		B_FIN,
		B_DRAIN
	} back_state_t;

endpackage

FILE: design/bpc_front.sv
`timescale 1ns / 1ps

module bpc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpc_pkg::in_item_t  in_data,
	output logic               w_valid,
	input  logic               w_ready,
	output bpc_pkg::work_t     w_data
);

	bpc_pkg::work_t q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	bpc_pkg::work_t cls;
	logic push;
	logic pop;

	// decode the command into an operation class
	always_comb begin
		cls.symbol = in_data.symbol;
		cls.last   = in_data.message_last;
		case (in_data.command)
			bpc_pkg::CMD_KEY_BYTE: cls.op = bpc_pkg::OP_KEY;
			bpc_pkg::CMD_KEY_DONE: cls.op = bpc_pkg::OP_DONE;
			bpc_pkg::CMD_ENCRYPT:  cls.op = bpc_pkg::OP_ENC;
			bpc_pkg::CMD_DECRYPT:  cls.op = bpc_pkg::OP_DEC;
			default:               cls.op = bpc_pkg::OP_KEY;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign w_valid  = (cnt_q != 2'd0);
	assign w_data   = q_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = w_valid && w_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

endmodule

FILE: design/bpc_back.sv
`timescale 1ns / 1ps

module bpc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 w_valid,
	output logic                 w_ready,
	input  bpc_pkg::work_t       w_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bpc_pkg::out_item_t   out_data,
	output bpc_pkg::bpc_status_t status
);

	typedef struct packed {
		logic [17:0] win;
		logic        emit;
		logic [7:0]  sym;
	} feed_t;

	// one step of the filler-removal window
	function automatic feed_t restore_feed(input logic [17:0] win, input logic [7:0] v);
		feed_t r;
		logic [8:0] held;
		logic [8:0] prior;
		held  = win[8:0];
		prior = win[17:9];
		r.emit = 1'b0;
		r.sym  = held[7:0];
		if (held[8]) begin
			r.emit = !((held[7:0] == bpc_pkg::FILLER) && prior[8] && (prior[7:0] == v));
			prior  = held;
		end else begin
			prior = 9'd0;
		end
		r.win = {prior, 1'b1, v};
		return r;
	endfunction

	bpc_pkg::back_state_t state_q, state_d;

	bpc_pkg::work_t cur_q;
	logic [1:0]   phase_q;
	logic [7:0]   pb_q;
	logic [7:0]   pend_q;
	logic         pend_v_q;
	logic [8:0]   prev_q;
	logic [17:0]  win_q;
	logic [8:0]   fill_q;
	logic [8:0]   v_q;
	logic [255:0] used_q;
	logic [7:0]   res_q [bpc_pkg::MAX_RESULTS];
	logic [2:0]   res_n_q;
	logic [1:0]   k_q;
	logic         err_q;

	logic [7:0] sq_mem  [bpc_pkg::CELLS];
	logic [7:0] pos_mem [bpc_pkg::CELLS];
	logic [7:0] sq_x_q, sq_y_q, pa_q, pb_pos_q;

	logic       we;
	logic [7:0] wi;
	logic [7:0] wv;
	logic [7:0] sq_ra, sq_rb;
	logic [3:0] sh;
	logic       fill_act;
	logic       fin;
	feed_t      f1, f2;

	// table write port
	always_comb begin
		we = 1'b0;
		wi = fill_q[7:0];
		wv = cur_q.symbol;
		fill_act = !v_q[8] && !fill_q[8];
		case (state_q)
			bpc_pkg::B_KEY: begin
				wv = cur_q.symbol;
				if (fill_q[8]) begin
					we = 1'b1;
					wi = 8'd0;
				end else begin
					we = !used_q[cur_q.symbol];
				end
			end
			bpc_pkg::B_FILL: begin
				wv = v_q[7:0];
				we = fill_act && !used_q[v_q[7:0]];
			end
			default: we = 1'b0;
		endcase
	end

	// square addresses from the two positions
	always_comb begin
		sh = (cur_q.op == bpc_pkg::OP_ENC) ? 4'd1 : 4'(bpc_pkg::SQUARE_SIDE - 1);
		if (pa_q[7:4] == pb_pos_q[7:4]) begin
			sq_ra = {pa_q[7:4], pa_q[3:0] + sh};
			sq_rb = {pb_pos_q[7:4], pb_pos_q[3:0] + sh};
		end else if (pa_q[3:0] == pb_pos_q[3:0]) begin
			sq_ra = {pa_q[7:4] + sh, pa_q[3:0]};
			sq_rb = {pb_pos_q[7:4] + sh, pb_pos_q[3:0]};
		end else begin
			sq_ra = {pa_q[7:4], pb_pos_q[3:0]};
			sq_rb = {pb_pos_q[7:4], pa_q[3:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			sq_mem[wi]  <= wv;
			pos_mem[wv] <= wi;
		end
		pa_q     <= pos_mem[pend_q];
		pb_pos_q <= pos_mem[pb_q];
		sq_x_q   <= sq_mem[sq_ra];
		sq_y_q   <= sq_mem[sq_rb];
	end

	always_comb begin
		f1 = restore_feed(win_q, sq_x_q);
		f2 = restore_feed(f1.win, sq_y_q);
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		w_ready   = 1'b0;
		out_valid = 1'b0;
		fin       = (k_q == 2'(res_n_q - 3'd1));
		out_data.out_symbol       = res_q[k_q];
		out_data.run_last         = fin;
		out_data.message_end      = fin && cur_q.last;
		out_data.odd_length_error = err_q;
		case (state_q)
			bpc_pkg::B_IDLE: begin
				w_ready = 1'b1;
				if (w_valid) begin
					case (w_data.op)
						bpc_pkg::OP_KEY:  state_d = bpc_pkg::B_KEY;
						bpc_pkg::OP_DONE: state_d = bpc_pkg::B_FILL;
						bpc_pkg::OP_ENC:  state_d = bpc_pkg::B_ENC0;
						bpc_pkg::OP_DEC:  state_d = bpc_pkg::B_PUSH;
						default:          state_d = bpc_pkg::B_IDLE;
					endcase
				end
			end
			bpc_pkg::B_KEY:  state_d = bpc_pkg::B_IDLE;
			bpc_pkg::B_FILL: state_d = fill_act ? bpc_pkg::B_FILL : bpc_pkg::B_IDLE;
			bpc_pkg::B_ENC0: state_d = bpc_pkg::B_PUSH;
			bpc_pkg::B_PUSH: state_d = pend_v_q ? bpc_pkg::B_POS : bpc_pkg::B_AFTER;
			bpc_pkg::B_POS:  state_d = bpc_pkg::B_SQ;
			bpc_pkg::B_SQ:   state_d = bpc_pkg::B_MAP;
			bpc_pkg::B_MAP:  state_d = bpc_pkg::B_AFTER;
			bpc_pkg::B_AFTER: begin
				state_d = bpc_pkg::B_FIN;
				if (cur_q.op == bpc_pkg::OP_ENC) begin
					if (phase_q == 2'd1) begin
						state_d = bpc_pkg::B_PUSH;
					end else if (phase_q == 2'd2 && cur_q.last && pend_v_q) begin
						state_d = bpc_pkg::B_PUSH;
					end
				end
			end
			bpc_pkg::B_FIN: state_d = (res_n_q == 3'd0) ? bpc_pkg::B_IDLE : bpc_pkg::B_DRAIN;
			bpc_pkg::B_DRAIN: begin
				out_valid = 1'b1;
				if (out_ready && fin) begin
					state_d = bpc_pkg::B_IDLE;
				end
			end
			default: state_d = bpc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpc_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 8'd0;
			pend_v_q <= 1'b0;
			prev_q   <= 9'd0;
			win_q    <= 18'd0;
			fill_q   <= 9'd0;
			v_q      <= 9'd0;
			used_q   <= '0;
			res_n_q  <= 3'd0;
			k_q      <= 2'd0;
			err_q    <= 1'b0;
			phase_q  <= 2'd0;
		end else begin
			case (state_q)
				bpc_pkg::B_IDLE: begin
					if (w_valid) begin
						res_n_q <= 3'd0;
						err_q   <= 1'b0;
						k_q     <= 2'd0;
						v_q     <= 9'd0;
						phase_q <= 2'd0;
					end
				end
				bpc_pkg::B_KEY: begin
					if (fill_q[8]) begin
						used_q <= 256'd1 << cur_q.symbol;
						fill_q <= 9'd1;
					end else if (!used_q[cur_q.symbol]) begin
						used_q[cur_q.symbol] <= 1'b1;
						fill_q <= fill_q + 9'd1;
					end
				end
				bpc_pkg::B_FILL: begin
					if (fill_act) begin
						if (!used_q[v_q[7:0]]) begin
							used_q[v_q[7:0]] <= 1'b1;
							fill_q <= fill_q + 9'd1;
						end
						v_q <= v_q + 9'd1;
					end else begin
						pend_q   <= 8'd0;
						pend_v_q <= 1'b0;
						prev_q   <= 9'd0;
						win_q    <= 18'd0;
					end
				end
				bpc_pkg::B_ENC0: begin
					if (prev_q[8] && prev_q[7:0] == cur_q.symbol) begin
						phase_q <= 2'd1;
					end else begin
						phase_q <= 2'd2;
					end
				end
				bpc_pkg::B_PUSH: begin
					if (!pend_v_q) begin
						pend_q   <= pb_q;
						pend_v_q <= 1'b1;
					end
				end
				bpc_pkg::B_MAP: begin
					pend_v_q <= 1'b0;
					if (cur_q.op == bpc_pkg::OP_ENC) begin
						res_q[res_n_q[1:0]]         <= sq_x_q;
						res_q[res_n_q[1:0] + 2'd1]  <= sq_y_q;
						res_n_q <= res_n_q + 3'd2;
					end else begin
						win_q <= f2.win;
						if (f1.emit) begin
							res_q[res_n_q[1:0]] <= f1.sym;
						end
						if (f2.emit) begin
							res_q[res_n_q[1:0] + {1'b0, f1.emit}] <= f2.sym;
						end
						res_n_q <= res_n_q + {2'b0, f1.emit} + {2'b0, f2.emit};
					end
				end
				bpc_pkg::B_AFTER: begin
					if (cur_q.op == bpc_pkg::OP_ENC) begin
						if (phase_q == 2'd1) begin
							phase_q <= 2'd2;
						end else if (phase_q == 2'd2) begin
							if (cur_q.last && !pend_v_q) begin
								pend_q <= 8'd0;
								prev_q <= 9'd0;
							end else begin
								prev_q <= {1'b1, cur_q.symbol};
								if (cur_q.last) begin
									phase_q <= 2'd3;
								end
							end
						end else begin
							pend_q   <= 8'd0;
							pend_v_q <= 1'b0;
							prev_q   <= 9'd0;
						end
					end else if (cur_q.last) begin
						if (pend_v_q) begin
							err_q    <= 1'b1;
							res_q[0] <= 8'd0;
							res_n_q  <= 3'd1;
						end else if (win_q[8]) begin
							res_q[res_n_q[1:0]] <= win_q[7:0];
							res_n_q <= res_n_q + 3'd1;
						end
						win_q    <= 18'd0;
						pend_q   <= 8'd0;
						pend_v_q <= 1'b0;
					end
				end
				bpc_pkg::B_DRAIN: begin
					if (out_ready && !fin) begin
						k_q <= k_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item registers and the byte to push next
	always_ff @(posedge clk) begin
		if (state_q == bpc_pkg::B_IDLE && w_valid) begin
			cur_q <= w_data;
			pb_q  <= w_data.symbol;
		end else if (state_q == bpc_pkg::B_ENC0) begin
			if (prev_q[8] && prev_q[7:0] == cur_q.symbol) begin
				pb_q <= bpc_pkg::FILLER;
			end
		end else if (state_q == bpc_pkg::B_AFTER && cur_q.op == bpc_pkg::OP_ENC) begin
			if (phase_q == 2'd1) begin
				pb_q <= cur_q.symbol;
			end else if (phase_q == 2'd2) begin
				pb_q <= bpc_pkg::FILLER;
			end
		end
	end

	assign status.draining = (state_q == bpc_pkg::B_DRAIN);
	assign status.res_n    = res_n_q;

endmodule

FILE: design/byte_playfair_cipher_stream.sv
`timescale 1ns / 1ps
// Byte Playfair cipher over a 16x16 square of all 256 byte values. Send key
// bytes (command 0), then key done (command 1), which walks the byte values
// once and holds the sequencer until the square is complete;
// no data should be sent before the first key done. Encrypt (2) and decrypt (3)
// requests carry one byte each with message_last on the final byte; each
// request gives zero to four result bytes, run_last flagging the last one.
// A request waits in the queue, then holds the sequencer: a key byte in the
// key state; a data byte in the push, after and finish states (encrypt checks
// for a repeat first), and when it closes a digraph also in the position,
// square, map and drain states, the drain handing out its results while
// out_ready is high. An inserted filler or padded tail adds another pass. The
// cost is set by the two registered table lookups (position, then square).
// A two-entry request queue lets new requests be taken while results wait.

`include "byte_playfair_cipher_stream_defines.svh"

module byte_playfair_cipher_stream (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bpc_pkg::out_item_t out_data
);

	// queue to sequencer link
	logic           w_valid;
	logic           w_ready;
	bpc_pkg::work_t w_data;
	bpc_pkg::bpc_status_t status;

	// front: takes requests, classifies them, buffers two
	bpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.w_valid  (w_valid),
		.w_ready  (w_ready),
		.w_data   (w_data)
	);

	// back: key tables, digraph mapping, filler handling, result drain
	bpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.w_valid   (w_valid),
		.w_ready   (w_ready),
		.w_data    (w_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.status    (status)
	);

	// result buffer never overfills
	`BPC_ASSERT_ALWAYS(a_res_bound, status.res_n <= 3'd4, "result count above four")
	// a result is shown only from a filled buffer
	`BPC_ASSERT_IMPL(a_out_has_res, out_valid, status.draining && status.res_n != 3'd0, "empty drain")
	// odd length error is a lone zero that ends the message
	`BPC_ASSERT_IMPL(a_err_shape, out_valid && out_data.odd_length_error,
		out_data.message_end && out_data.run_last && out_data.out_symbol == 8'd0, "bad error result")

endmodule

FILE: bench/byte_playfair_cipher_stream_tb.sv
`timescale 1ns / 1ps

module byte_playfair_cipher_stream_tb;
	import bpc_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 250;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	byte_playfair_cipher_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// cipher state mirrored by the predictor
	logic [7:0] square[256];
	logic [7:0] where_is[256];
	logic       taken[256];
	int         filled;
	logic [7:0] open_byte;
	logic       open_valid;
	logic [7:0] last_plain;
	logic       last_plain_valid;
	logic [7:0] held_byte;
	logic       held_valid;
	logic [7:0] prior_byte;
	logic       prior_valid;

	// result bytes produced by the current request
	logic [7:0] run_bytes[4];
	int         run_count;

	out_item_t  expected_bytes[$];
	int         errors;
	int         requests_sent;
	int         bytes_checked;
	int         odd_errors_seen;
	int         idle_cycles;
	int         hold_asked;
	int         hold_seen;
	int         hold_left;
	int         rx_wait;
	logic       rx_taken;

	task report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	task add_byte(input logic [7:0] b);
		if (run_count < 4) begin
			run_bytes[run_count] = b;
			run_count++;
		end
	endtask

	// digraph rules; shift 1 encrypts, 15 decrypts, 4-bit math wraps the square
	task map_pair(input logic [7:0] a, input logic [7:0] b, input logic [3:0] shift,
			output logic [7:0] x, output logic [7:0] y);
		logic [7:0] pa, pb;
		pa = where_is[a];
		pb = where_is[b];
		if (pa[7:4] == pb[7:4]) begin
			x = square[{pa[7:4], pa[3:0] + shift}];
			y = square[{pb[7:4], pb[3:0] + shift}];
		end else if (pa[3:0] == pb[3:0]) begin
			x = square[{pa[7:4] + shift, pa[3:0]}];
			y = square[{pb[7:4] + shift, pb[3:0]}];
		end else begin
			x = square[{pa[7:4], pb[3:0]}];
			y = square[{pb[7:4], pa[3:0]}];
		end
	endtask

	task encrypt_push(input logic [7:0] b);
		logic [7:0] x, y;
		if (!open_valid) begin
			open_byte = b;
			open_valid = 1'b1;
		end else begin
			map_pair(open_byte, b, 4'd1, x, y);
			add_byte(x);
			add_byte(y);
			open_valid = 1'b0;
		end
	endtask

	// drops an inner filler whose two neighbors match
	task restore_feed(input logic [7:0] v);
		if (held_valid) begin
			if (!(held_byte == FILLER && prior_valid && prior_byte == v))
				add_byte(held_byte);
			prior_valid = 1'b1;
			prior_byte = held_byte;
		end else begin
			prior_valid = 1'b0;
			prior_byte = 8'd0;
		end
		held_valid = 1'b1;
		held_byte = v;
	endtask

	task decrypt_push(input logic [7:0] b);
		logic [7:0] x, y;
		if (!open_valid) begin
			open_byte = b;
			open_valid = 1'b1;
		end else begin
			map_pair(open_byte, b, 4'd15, x, y);
			open_valid = 1'b0;
			restore_feed(x);
			restore_feed(y);
		end
	endtask

	task clear_message;
		open_byte = 8'd0;
		open_valid = 1'b0;
		last_plain = 8'd0;
		last_plain_valid = 1'b0;
		held_valid = 1'b0;
		prior_valid = 1'b0;
	endtask

	// works out the result bytes of one accepted request and queues them
	task predict_cipher(input in_item_t it, input logic use_typed, input out_item_t typed);
		logic err;
		out_item_t r;
		err = 1'b0;
		run_count = 0;
		case (it.command)
			CMD_KEY_BYTE: begin
				if (filled >= CELLS) begin
					for (int v = 0; v < CELLS; v++)
						taken[v] = 1'b0;
					filled = 0;
				end
				if (!taken[it.symbol]) begin
					square[filled[7:0]] = it.symbol;
					where_is[it.symbol] = filled[7:0];
					taken[it.symbol] = 1'b1;
					filled++;
				end
			end
			CMD_KEY_DONE: begin
				for (int v = 0; v < CELLS; v++) begin
					if (filled < CELLS && !taken[v]) begin
						square[filled[7:0]] = v[7:0];
						where_is[v] = filled[7:0];
						taken[v] = 1'b1;
						filled++;
					end
				end
				clear_message();
			end
			CMD_ENCRYPT: begin
				if (last_plain_valid && last_plain == it.symbol)
					encrypt_push(FILLER);
				encrypt_push(it.symbol);
				last_plain = it.symbol;
				last_plain_valid = 1'b1;
				if (it.message_last) begin
					if (open_valid)
						encrypt_push(FILLER);
					open_valid = 1'b0;
					open_byte = 8'd0;
					last_plain_valid = 1'b0;
					last_plain = 8'd0;
				end
			end
			default: begin
				decrypt_push(it.symbol);
				if (it.message_last) begin
					if (open_valid) begin
						// lone ciphertext byte: one error result replaces the run
						err = 1'b1;
						run_count = 0;
						add_byte(8'd0);
						held_valid = 1'b0;
						prior_valid = 1'b0;
					end else begin
						if (held_valid)
							add_byte(held_byte);
						held_valid = 1'b0;
						prior_valid = 1'b0;
					end
					open_valid = 1'b0;
					open_byte = 8'd0;
				end
			end
		endcase
		for (int k = 0; k < run_count; k++) begin
			r.out_symbol = run_bytes[k];
			r.run_last = (k == run_count - 1);
			r.message_end = (k == run_count - 1) && it.message_last;
			r.odd_length_error = err;
			if (use_typed && run_count == 1)
				r = typed;
			expected_bytes.push_back(r);
		end
	endtask

	// one request: random gap, then valid held until accepted
	task send_request(input in_item_t it, input logic use_typed, input out_item_t typed);
		int gap;
		gap = $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_cipher(it, use_typed, typed);
		requests_sent++;
	endtask

	task send_plain(input logic [1:0] cmd, input logic [7:0] sym, input logic last);
		in_item_t it;
		it.command = cmd;
		it.symbol = sym;
		it.message_last = last;
		send_request(it, 1'b0, '0);
	endtask

	// output check against the oldest expected byte
	always @(posedge clk) begin
		out_item_t want;
		rx_taken <= arst_n && out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				report("unexpected result", out_data, 0);
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.odd_length_error)
					odd_errors_seen++;
				if (out_data.out_symbol !== want.out_symbol)
					report("out_symbol", out_data.out_symbol, want.out_symbol);
				if (out_data.run_last !== want.run_last)
					report("run_last", out_data.run_last, want.run_last);
				if (out_data.message_end !== want.message_end)
					report("message_end", out_data.message_end, want.message_end);
				if (out_data.odd_length_error !== want.odd_length_error)
					report("odd_length_error", out_data.odd_length_error,
						want.odd_length_error);
			end
		end
	end

	// receiver: random wait per byte, plus one long hold when asked
	always @(negedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (rx_taken)
			rx_wait = $urandom_range(0, 5);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// directed rows: command, symbol, last, typed flag, typed result
	typedef struct {
		logic [1:0] cmd;
		logic [7:0] sym;
		logic       last;
		logic       typed;
		out_item_t  res;
	} row_t;

	row_t rows[] = '{
		'{CMD_KEY_BYTE, 8'h00, 1'b0, 1'b0, '0},
		'{CMD_KEY_BYTE, 8'hFF, 1'b0, 1'b0, '0},
		'{CMD_KEY_BYTE, 8'h41, 1'b0, 1'b0, '0},
		'{CMD_KEY_BYTE, 8'h41, 1'b0, 1'b0, '0},   // repeat is skipped
		'{CMD_KEY_BYTE, 8'h80, 1'b1, 1'b0, '0},   // last flag ignored on key
		'{CMD_KEY_DONE, 8'h55, 1'b1, 1'b0, '0},
		'{CMD_KEY_DONE, 8'hAA, 1'b0, 1'b0, '0},   // second done fills nothing
		'{CMD_ENCRYPT,  8'h00, 1'b0, 1'b0, '0},
		'{CMD_ENCRYPT,  8'h00, 1'b0, 1'b0, '0},   // equal neighbors get a filler
		'{CMD_ENCRYPT,  8'hFF, 1'b1, 1'b0, '0},
		'{CMD_ENCRYPT,  8'h41, 1'b1, 1'b0, '0},   // odd tail padded
		'{CMD_DECRYPT,  8'h12, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
		'{CMD_DECRYPT,  8'h01, 1'b0, 1'b0, '0},
		'{CMD_DECRYPT,  8'h02, 1'b0, 1'b0, '0},
		'{CMD_DECRYPT,  8'h03, 1'b0, 1'b0, '0},
		'{CMD_DECRYPT,  8'h04, 1'b1, 1'b0, '0},
		'{CMD_ENCRYPT,  8'h10, 1'b0, 1'b0, '0},   // mixed modes share the open byte
		'{CMD_DECRYPT,  8'h20, 1'b1, 1'b0, '0},
		'{CMD_DECRYPT,  8'hFF, 1'b0, 1'b0, '0},
		'{CMD_DECRYPT,  8'hFF, 1'b1, 1'b0, '0},
		'{CMD_ENCRYPT,  8'hFF, 1'b0, 1'b0, '0},
		'{CMD_ENCRYPT,  8'hFF, 1'b1, 1'b0, '0},
		'{CMD_KEY_BYTE, 8'h7E, 1'b0, 1'b0, '0},   // new key after done
		'{CMD_KEY_DONE, 8'h00, 1'b0, 1'b0, '0}
	};

	logic [7:0] plain_q[$];
	logic [7:0] cipher_q[$];

	initial begin
		in_item_t it;
		int kind, len, pick;
		logic [7:0] x, y, pool[4];
		errors = 0;
		requests_sent = 0;
		bytes_checked = 0;
		odd_errors_seen = 0;
		idle_cycles = 0;
		hold_asked = 0;
		hold_seen = 0;
		hold_left = 0;
		rx_wait = 0;
		filled = 0;
		for (int v = 0; v < CELLS; v++) begin
			square[v] = 8'd0;
			where_is[v] = 8'd0;
			taken[v] = 1'b0;
		end
		clear_message();
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			it.command = rows[i].cmd;
			it.symbol = rows[i].sym;
			it.message_last = rows[i].last;
			send_request(it, rows[i].typed, rows[i].res);
		end

		// random part, mostly well-formed messages
		while (requests_sent < RANDOM_ITEMS) begin
			if (requests_sent > rows.size() + 100 && hold_asked == 0)
				hold_asked = 1;
			kind = $urandom_range(0, 99);
			for (int k = 0; k < 4; k++)
				pool[k] = ($urandom_range(0, 3) == 0) ? FILLER : 8'($urandom_range(0, 255));
			if (kind < 6) begin
				len = $urandom_range(1, 20);
				for (int k = 0; k < len; k++)
					send_plain(CMD_KEY_BYTE, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				send_plain(CMD_KEY_DONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (kind < 46) begin
				len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++)
					send_plain(CMD_ENCRYPT, pool[$urandom_range(0, 3)], k == len - 1);
			end else if (kind < 80) begin
				// ciphertext of a plaintext with repeats, so fillers get dropped
				plain_q.delete();
				cipher_q.delete();
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					pick = $urandom_range(0, 3);
					if (plain_q.size() > 0 && plain_q[$] == pool[pick])
						plain_q.push_back(FILLER);
					plain_q.push_back(pool[pick]);
				end
				if (plain_q.size() % 2)
					plain_q.push_back(FILLER);
				for (int k = 0; k < plain_q.size(); k += 2) begin
					map_pair(plain_q[k], plain_q[k + 1], 4'd1, x, y);
					cipher_q.push_back(x);
					cipher_q.push_back(y);
				end
				foreach (cipher_q[k])
					send_plain(CMD_DECRYPT, cipher_q[k], k == cipher_q.size() - 1);
			end else begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_plain(2'($urandom_range(2, 3)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d requests (keys, encrypt, decrypt, noise), checked %0d bytes",
			requests_sent, bytes_checked);
		$display("odd-length errors seen %0d, one long output hold applied", odd_errors_seen);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
